// File: src/rc_button_action_decoder_core_assert.svh
// assertion macros shared by the rc button action decoder rtl
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef RC_BUTTON_ACTION_DECODER_CORE_ASSERT_SVH
`define RC_BUTTON_ACTION_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RCBAD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RCBAD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/rcbad_pkg.sv
// shared types, constants and helpers of the rc button action decoder
// no dependencies
`default_nettype none

package rcbad_pkg;

  // tuning
  localparam int LONG_PRESS_TICKS    = 15;
  localparam int COMMAND_DELAY_TICKS = 15;
  localparam int RIGHT_PRESS_TICKS   = 1;

  // field widths
  localparam int PULSE_W    = 12;
  localparam int TIME_W     = 32;
  localparam int CODE_W     = 5;
  localparam int SLOT_W     = 4;
  localparam int NUM_SLOTS  = 9;
  localparam int MAP_W      = CODE_W * NUM_SLOTS;
  localparam int CNT_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 16;

  // pulse thresholds in microseconds, action gap in milliseconds
  localparam logic [PULSE_W-1:0] TOGGLE_LEVEL = 12'd1700;
  localparam logic [PULSE_W-1:0] LEFT_HIGH    = 12'd2050;
  localparam logic [PULSE_W-1:0] LEFT_BAND_LO = 12'd1050;
  localparam logic [PULSE_W-1:0] LEFT_BAND_HI = 12'd1150;
  localparam logic [PULSE_W-1:0] RIGHT_LEVEL  = 12'd1500;
  localparam logic [PULSE_W-1:0] BITS_BASE    = 12'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MIN    = 12'd900;
  localparam logic [TIME_W-1:0]  ACTION_GAP_MS = 32'd200;

  // divide by 100 as multiply by 1311 and shift by 17 (exact for values below 4096)
  localparam logic [10:0] DIV100_MUL = 11'd1311;
  localparam int          DIV100_SH  = 17;

  // counter limits
  localparam int CNT_MAX_INT     = 31;
  localparam int PRELOAD_INT     = (COMMAND_DELAY_TICKS > 32) ? -32 : -COMMAND_DELAY_TICKS;
  localparam logic signed [CNT_W-1:0] CNT_PRELOAD = CNT_W'(PRELOAD_INT);

  localparam logic [MAP_W-1:0] MAP_RESET = 45'd22010633668642;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP    = 1'd1;

  // table slots
  localparam logic [SLOT_W-1:0] SLOT_TOGGLE = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_LONG   = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_RIGHT  = 4'd8;
  localparam logic [SLOT_W-1:0] NO_SLOT     = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_HELD   = 4'd3;

  // action codes
  localparam logic [CODE_W-1:0] ACT_NONE         = 5'd0;
  localparam logic [CODE_W-1:0] ACT_PHOTO        = 5'd1;
  localparam logic [CODE_W-1:0] ACT_VIDEO        = 5'd2;
  localparam logic [CODE_W-1:0] ACT_TOGGLE_FIRST = 5'd19;
  localparam logic [CODE_W-1:0] ACT_TOGGLE_LAST  = 5'd22;

  typedef struct packed {
    logic                 enable;
    logic [MAP_W-1:0]     action_map;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]    now_ms;
    logic                 radio_lost;
    logic [PULSE_W-1:0]   action_pulse;
    logic [PULSE_W-1:0]   right_pulse;
    logic [PULSE_W-1:0]   mode_pulse;
  } item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]    slot;
    logic [CODE_W-1:0]    action;
  } result_t;

  // code held in one slot of the action map
  function automatic logic [CODE_W-1:0] slot_code(input logic [MAP_W-1:0] map,
                                                  input logic [SLOT_W-1:0] slot);
    return CODE_W'(map >> (CODE_W * int'(slot)));
  endfunction

  // saturating increment of a hold counter
  function automatic logic signed [CNT_W-1:0] count_up(input logic signed [CNT_W-1:0] c);
    return (int'(c) >= CNT_MAX_INT) ? CNT_W'(CNT_MAX_INT) : c + CNT_W'(1);
  endfunction

  // codes that are held off for the gap time
  function automatic logic rate_limited(input logic [CODE_W-1:0] code);
    return (code == ACT_PHOTO) || (code == ACT_VIDEO) ||
           ((code >= ACT_TOGGLE_FIRST) && (code <= ACT_TOGGLE_LAST));
  endfunction

endpackage

`default_nettype wire

// File: src/rcbad_cfg.sv
// configuration registers of the rc button action decoder
// depends on rcbad_pkg
`default_nettype none

module rcbad_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            we_i,
  input  wire logic [rcbad_pkg::CFG_IDX_W-1:0] idx_i,
  input  wire logic [rcbad_pkg::MAP_W-1:0]     wdata_i,
  output      rcbad_pkg::cfg_t                 cfg_o
);
  import rcbad_pkg::*;

  cfg_t cfg_q, cfg_d;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        REG_ENABLE: cfg_d.enable     = wdata_i[0];
        REG_MAP:    cfg_d.action_map = wdata_i;
        default:    cfg_d            = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= 1'b0;
      cfg_q.action_map <= MAP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/rcbad_decide.sv
// button decode, hold counters, toggle detect, table lookup and rate limit
// depends on rcbad_pkg and rc_button_action_decoder_core_assert.svh
`default_nettype none

module rcbad_decide (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     upd_i,
  input  wire rcbad_pkg::item_t   item_i,
  input  wire rcbad_pkg::cfg_t    cfg_i,
  output rcbad_pkg::result_t res_o
);
  import rcbad_pkg::*;

  `include "rc_button_action_decoder_core_assert.svh"

  logic [PULSE_W-1:0]      prev_mode_q, prev_mode_d;
  logic signed [CNT_W-1:0] left_cnt_q, left_cnt_d;
  logic signed [CNT_W-1:0] right_cnt_q, right_cnt_d;
  logic                    skip_q, skip_d;
  logic [TIME_W-1:0]       last_time_q, last_time_d;

  logic                    active;
  logic                    toggle;
  logic                    left;
  logic                    right;
  logic [PULSE_W-1:0]      bits_diff;
  logic [22:0]             bits_prod;
  logic [2:0]              btn;
  logic                    has_sel;
  logic [SLOT_W-1:0]       sel_slot;
  logic signed [CNT_W-1:0] left_up;
  logic signed [CNT_W-1:0] right_up;
  logic                    skip_pre;
  logic                    toggle_eff;
  logic [TIME_W-1:0]       gap;
  logic [CODE_W-1:0]       act;
  logic [SLOT_W-1:0]       slot;
  logic [CODE_W-1:0]       act_final;

  // channel decode
  assign active = cfg_i.enable && !item_i.radio_lost && (item_i.mode_pulse >= PULSE_MIN);
  assign toggle = (item_i.mode_pulse > TOGGLE_LEVEL) != (prev_mode_q > TOGGLE_LEVEL);
  assign left   = (item_i.mode_pulse > LEFT_HIGH) ||
                  ((item_i.mode_pulse > LEFT_BAND_LO) && (item_i.mode_pulse < LEFT_BAND_HI));
  assign right  = item_i.right_pulse > RIGHT_LEVEL;

  // action channel bits, (width - 1000) / 100 by reciprocal
  assign bits_diff = (item_i.action_pulse > BITS_BASE) ? item_i.action_pulse - BITS_BASE
                                                       : '0;
  assign bits_prod = 23'(bits_diff) * 23'(DIV100_MUL);
  assign btn       = bits_prod[DIV100_SH+2:DIV100_SH];

  assign left_up  = count_up(left_cnt_q);
  assign right_up = count_up(right_cnt_q);
  assign gap      = item_i.now_ms - last_time_q;

  // priority chain of action sources
  always_comb begin
    has_sel     = 1'b1;
    sel_slot    = '0;
    act         = ACT_NONE;
    slot        = NO_SLOT;
    left_cnt_d  = left_cnt_q;
    right_cnt_d = right_cnt_q;
    skip_pre    = skip_q;
    skip_d      = skip_q;
    toggle_eff  = toggle;

    priority if (btn[0]) sel_slot = 4'd0;
    else if (btn[1])     sel_slot = 4'd1;
    else if (btn[2])     sel_slot = 4'd2;
    else                 has_sel  = 1'b0;

    if (has_sel && left) begin
      sel_slot   = sel_slot + SLOT_HELD;
      left_cnt_d = '0;
    end else if (left) begin
      left_cnt_d = left_up;
    end else begin
      left_cnt_d = '0;
    end

    if (has_sel) begin
      act  = slot_code(cfg_i.action_map, sel_slot);
      slot = sel_slot;
    end

    // long left press
    if ((act == ACT_NONE) && (int'(left_cnt_d) > LONG_PRESS_TICKS)) begin
      left_cnt_d = CNT_PRELOAD;
      act        = slot_code(cfg_i.action_map, SLOT_LONG);
      slot       = SLOT_LONG;
      skip_pre   = 1'b1;
    end

    // first toggle after a long press is swallowed
    skip_d = skip_pre;
    if (skip_pre && toggle) begin
      toggle_eff = 1'b0;
      skip_d     = 1'b0;
    end

    if ((act == ACT_NONE) && toggle_eff) begin
      act  = slot_code(cfg_i.action_map, SLOT_TOGGLE);
      slot = SLOT_TOGGLE;
    end

    // right button repeat
    if ((act == ACT_NONE) && right) begin
      right_cnt_d = right_up;
      if (int'(right_up) >= RIGHT_PRESS_TICKS) begin
        act         = slot_code(cfg_i.action_map, SLOT_RIGHT);
        slot        = SLOT_RIGHT;
        right_cnt_d = CNT_PRELOAD;
      end
    end else begin
      right_cnt_d = '0;
    end
  end

  // rate limit and final result
  always_comb begin
    act_final = act;
    if (rate_limited(act) && (gap < ACTION_GAP_MS)) begin
      act_final = ACT_NONE;
    end
    res_o.action = active ? act_final : ACT_NONE;
    res_o.slot   = (active && (act_final != ACT_NONE)) ? slot : NO_SLOT;
    prev_mode_d  = item_i.mode_pulse;
    last_time_d  = (act_final != ACT_NONE) ? item_i.now_ms : last_time_q;
  end

  // decoder state, stepped once per active word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mode_q <= '0;
      left_cnt_q  <= '0;
      right_cnt_q <= '0;
      skip_q      <= 1'b0;
      last_time_q <= '0;
    end else if (upd_i && active) begin
      prev_mode_q <= prev_mode_d;
      left_cnt_q  <= left_cnt_d;
      right_cnt_q <= right_cnt_d;
      skip_q      <= skip_d;
      last_time_q <= last_time_d;
    end
  end

  `RCBAD_ASSERT_NOW(a_slot_matches_action, 1'b1,
    (res_o.action == ACT_NONE) == (res_o.slot == NO_SLOT), "slot and action disagree")
  `RCBAD_ASSERT_NEXT(a_state_holds_idle, !(upd_i && active),
    $stable(left_cnt_q) && $stable(right_cnt_q) && $stable(skip_q) && $stable(last_time_q),
    "decoder state moved without an active word")
  `RCBAD_ASSERT_NEXT(a_stamp_on_action, upd_i && (res_o.action != ACT_NONE),
    last_time_q == $past(item_i.now_ms), "time stamp not taken on an action")

endmodule

`default_nettype wire

// File: src/rc_button_action_decoder_core.sv
// rc button action decoder: stream in, one action word out per tick word
//
// Slave channel s_axis_* takes one tick word (three pulse widths, the
// failsafe flag in tuser and the millisecond time). Master channel m_axis_*
// gives one word per accepted input: the action code and the table slot,
// slot 9 with action 0 when nothing fires. The cfg_* port writes the enable
// bit (index 0) and the 45-bit action map (index 1).
// An accepted word is held in an input register; once the output register is
// free or being read, the decode logic steps the button state and loads the
// result into the output register. One word is taken every cycle while the
// receiver is ready, set by the single decode stage between the two registers.
// Reset clears the hold counters, toggle history, time stamp and both
// pipeline valid flags; the block comes up disabled with the default map.
// When the receiver stalls the output word holds, the input register keeps
// its word and tready drops once both registers are full.
// depends on rcbad_pkg, rcbad_cfg, rcbad_decide and the assertion header
`default_nettype none

module rc_button_action_decoder_core (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // fields low to high: mode_pulse, right_pulse, action_pulse, now_ms, zero pad
  input  wire logic [rcbad_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // radio_lost
  input  wire logic                             s_axis_tuser,
  input  wire logic                             s_axis_tvalid,
  output      logic                             s_axis_tready,
  // fields low to high: action, slot, zero pad
  output      logic [rcbad_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output      logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic                             cfg_we_i,
  input  wire logic [rcbad_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [rcbad_pkg::MAP_W-1:0]      cfg_wdata_i
);
  import rcbad_pkg::*;

  `include "rc_button_action_decoder_core_assert.svh"

  cfg_t    cfg;
  item_t   in_q, in_d;
  logic    in_vld_q, in_vld_d;
  result_t res;
  result_t out_q, out_d;
  logic    out_vld_q, out_vld_d;
  logic    advance;
  logic    take;

  rcbad_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  rcbad_decide u_decide (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (advance),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // handshake and pipeline control
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign take          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_d.mode_pulse   = s_axis_tdata[11:0];
    in_d.right_pulse  = s_axis_tdata[23:12];
    in_d.action_pulse = s_axis_tdata[35:24];
    in_d.now_ms       = s_axis_tdata[67:36];
    in_d.radio_lost   = s_axis_tuser;
    in_vld_d          = take || (in_vld_q && !advance);
    out_d             = res;
    out_vld_d         = advance || (out_vld_q && !m_axis_tready);
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - CODE_W - SLOT_W){1'b0}}, out_q.slot, out_q.action};

  `RCBAD_ASSERT_NOW(a_no_overwrite, out_vld_q && !m_axis_tready, !advance,
    "output word overwritten while stalled")
  `RCBAD_ASSERT_NOW(a_ready_when_empty, !in_vld_q, s_axis_tready,
    "input refused with an empty input register")
  `RCBAD_ASSERT_NEXT(a_result_follows, advance, m_axis_tvalid,
    "decoded word not presented")

endmodule

`default_nettype wire
